>>> rtl/core/audio_channel_remix_core_defines.svh
// ----------------------------------------------------------------------------
// Audio channel remix: assertion macros
// Shared concurrent assertion macros, clocked on clk_i; ACRM_ASSERT is off during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_CHANNEL_REMIX_CORE_DEFINES_SVH
`define AUDIO_CHANNEL_REMIX_CORE_DEFINES_SVH

// Plain clocked check, disabled while reset is asserted.
`define ACRM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define ACRM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/acrm_pkg.sv
// ----------------------------------------------------------------------------
// Audio channel remix package
// Layout codes, register indexes, frame types and the fixed-point helpers.
// ----------------------------------------------------------------------------
package acrm_pkg;

  localparam int unsigned NumCh     = 6;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AccW      = 20;
  localparam int unsigned ProdW     = 36;
  localparam int unsigned GainShift = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned LayoutW   = 2;

  typedef enum logic [LayoutW-1:0] {
    LayMono   = 2'd0,
    LayStereo = 2'd1,
    LayQuad   = 2'd2,
    LaySix    = 2'd3
  } layout_e;

  localparam logic [CfgIdxW-1:0] CfgSrcIdx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOutIdx = 2'd1;

  // 0.7071 in Q15
  localparam logic signed [ProdW-1:0] GainQ15 = 36'sd23170;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0]    acc_t;

  typedef struct packed {
    layout_e src;
    layout_e dst;
  } cfg_t;

  typedef struct packed {
    sample_t [NumCh-1:0] ch;
    logic                last;
  } frame_t;

  function automatic acc_t gain(input acc_t a);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * GainQ15;
    return acc_t'(p >>> GainShift);
  endfunction

  function automatic sample_t sat16(input acc_t v);
    sample_t r;
    if (v > acc_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -acc_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/acrm_cfg.sv
// ----------------------------------------------------------------------------
// Audio channel remix: configuration registers
// Holds the source and output layout codes written over the config channel.
// ----------------------------------------------------------------------------
module acrm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acrm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [acrm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output acrm_pkg::cfg_t                 cfg_o
);

  acrm_pkg::layout_e src_q, src_d;
  acrm_pkg::layout_e dst_q, dst_d;
  logic              wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    src_d = src_q;
    dst_d = dst_q;
    if (wr) begin
      case (cfg_index_i)
        acrm_pkg::CfgSrcIdx: src_d = acrm_pkg::layout_e'(cfg_wdata_i[acrm_pkg::LayoutW-1:0]);
        acrm_pkg::CfgOutIdx: dst_d = acrm_pkg::layout_e'(cfg_wdata_i[acrm_pkg::LayoutW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= acrm_pkg::LayStereo;
      dst_q <= acrm_pkg::LayStereo;
    end else begin
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

  assign cfg_o.src = src_q;
  assign cfg_o.dst = dst_q;

endmodule

>>> rtl/core/acrm_mix.sv
// ----------------------------------------------------------------------------
// Audio channel remix: mixing matrix
// Maps one registered frame to the output layout and saturates to 16 bits.
// ----------------------------------------------------------------------------
module acrm_mix (
  input  acrm_pkg::cfg_t   cfg_i,
  input  acrm_pkg::frame_t frame_i,
  output acrm_pkg::frame_t frame_o
);

  acrm_pkg::acc_t x [acrm_pkg::NumCh];
  acrm_pkg::acc_t y [acrm_pkg::NumCh];
  acrm_pkg::acc_t m0_in, m1_in, m0, m1;
  int unsigned    n_pass;

  always_comb begin
    for (int i = 0; i < acrm_pkg::NumCh; i++) begin
      x[i] = acrm_pkg::acc_t'(acrm_pkg::sample_t'(frame_i.ch[i]));
    end
  end

  // two shared gain multipliers for the 5.1 downmixes
  always_comb begin
    case (cfg_i.dst)
      acrm_pkg::LayMono: begin
        m0_in = x[0] + x[1];
        m1_in = x[2] + x[5];
      end
      acrm_pkg::LayQuad: begin
        m0_in = x[2];
        m1_in = x[2];
      end
      default: begin
        m0_in = x[2] + x[4];
        m1_in = x[2] + x[5];
      end
    endcase
    m0 = acrm_pkg::gain(m0_in);
    m1 = acrm_pkg::gain(m1_in);
  end

  always_comb begin
    case (cfg_i.dst)
      acrm_pkg::LayMono:   n_pass = 1;
      acrm_pkg::LayStereo: n_pass = 2;
      acrm_pkg::LayQuad:   n_pass = 4;
      default:             n_pass = 6;
    endcase
  end

  always_comb begin
    for (int i = 0; i < acrm_pkg::NumCh; i++) begin
      y[i] = '0;
    end
    if (cfg_i.src == cfg_i.dst) begin
      for (int i = 0; i < acrm_pkg::NumCh; i++) begin
        if (i < n_pass) y[i] = x[i];
      end
    end else begin
      case (cfg_i.src)
        acrm_pkg::LayMono: begin
          if (cfg_i.dst == acrm_pkg::LaySix) begin
            y[2] = x[0];
          end else begin
            y[0] = x[0];
            y[1] = x[0];
          end
        end
        acrm_pkg::LayStereo: begin
          if (cfg_i.dst == acrm_pkg::LayMono) begin
            y[0] = (x[0] + x[1]) >>> 1;
          end else begin
            y[0] = x[0];
            y[1] = x[1];
          end
        end
        acrm_pkg::LayQuad: begin
          case (cfg_i.dst)
            acrm_pkg::LayMono: y[0] = (x[0] + x[1] + x[2] + x[3]) >>> 2;
            acrm_pkg::LayStereo: begin
              y[0] = (x[0] + x[2]) >>> 1;
              y[1] = (x[1] + x[3]) >>> 1;
            end
            default: begin
              y[0] = x[0];
              y[1] = x[1];
              y[4] = x[2];
              y[5] = x[3];
            end
          endcase
        end
        default: begin
          // 5.1 source; LFE dropped
          case (cfg_i.dst)
            acrm_pkg::LayMono: y[0] = m0 + x[2] + ((x[4] + x[5]) >>> 1);
            acrm_pkg::LayStereo: begin
              y[0] = x[0] + m0;
              y[1] = x[1] + m1;
            end
            default: begin
              y[0] = x[0] + m0;
              y[1] = x[1] + m1;
              y[2] = x[4];
              y[3] = x[5];
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < acrm_pkg::NumCh; i++) begin
      frame_o.ch[i] = acrm_pkg::sat16(y[i]);
    end
    frame_o.last = frame_i.last;
  end

endmodule

>>> rtl/core/audio_channel_remix_core.sv
// ----------------------------------------------------------------------------
// Audio channel remix core
// Up/down-mixes one frame of up to six Q1.15 samples between 1/2/4/6 layouts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with in_ch0_i..in_ch5_i and block_end_i; an
//   item is taken on a clock edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with out_ch0_o..out_ch5_o and frame_last_o;
//   an item leaves on an edge with out_valid_o high and out_stall_i low.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 = source
//   layout, 1 = output layout, others ignored) and cfg_wdata_i (low 2 bits
//   kept). Write only while no item is in flight.
//   From accept to out_valid_o an item passes an input register, the mixing
//   matrix, a result register. One item per cycle unless the receiver stalls.
//   If the receiver stalls, the result register holds and the input register
//   still takes one more item; in_stall_o rises only when both are full.
//   Reset empties both registers and sets both layouts to stereo.
// ----------------------------------------------------------------------------
`include "audio_channel_remix_core_defines.svh"

module audio_channel_remix_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             in_ch0_i,
  input  logic signed [15:0]             in_ch1_i,
  input  logic signed [15:0]             in_ch2_i,
  input  logic signed [15:0]             in_ch3_i,
  input  logic signed [15:0]             in_ch4_i,
  input  logic signed [15:0]             in_ch5_i,
  input  logic                           block_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             out_ch0_o,
  output logic signed [15:0]             out_ch1_o,
  output logic signed [15:0]             out_ch2_o,
  output logic signed [15:0]             out_ch3_o,
  output logic signed [15:0]             out_ch4_o,
  output logic signed [15:0]             out_ch5_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acrm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [acrm_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  acrm_pkg::cfg_t   cfg;
  acrm_pkg::frame_t in_q, in_d, mix, res_q, res_d;
  logic             in_vld_q, in_vld_d, res_vld_q, res_vld_d;
  logic             res_adv, in_adv, accept;

  acrm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  acrm_mix u_mix (
    .cfg_i  (cfg),
    .frame_i(in_q),
    .frame_o(mix)
  );

  assign res_adv    = !res_vld_q || !out_stall_i;
  assign in_adv     = !in_vld_q || res_adv;
  assign in_stall_o = !in_adv;
  assign accept     = in_valid_i && in_adv;

  always_comb begin
    in_d      = in_q;
    in_vld_d  = in_vld_q;
    res_d     = res_q;
    res_vld_d = res_vld_q;
    if (in_adv) begin
      in_vld_d = in_valid_i;
    end
    if (accept) begin
      in_d.ch[0] = in_ch0_i;
      in_d.ch[1] = in_ch1_i;
      in_d.ch[2] = in_ch2_i;
      in_d.ch[3] = in_ch3_i;
      in_d.ch[4] = in_ch4_i;
      in_d.ch[5] = in_ch5_i;
      in_d.last  = block_end_i;
    end
    if (res_adv) begin
      res_vld_d = in_vld_q;
      if (in_vld_q) res_d = mix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  assign out_valid_o  = res_vld_q;
  assign out_ch0_o    = res_q.ch[0];
  assign out_ch1_o    = res_q.ch[1];
  assign out_ch2_o    = res_q.ch[2];
  assign out_ch3_o    = res_q.ch[3];
  assign out_ch4_o    = res_q.ch[4];
  assign out_ch5_o    = res_q.ch[5];
  assign frame_last_o = res_q.last;

  `ACRM_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> (in_vld_q && res_vld_q), "stall with free slot")
  `ACRM_ASSERT(a_accept_fill, accept |=> in_vld_q, "accepted item lost from input register")
  `ACRM_ASSERT(a_move_on, (in_vld_q && res_adv) |=> res_vld_q, "item lost between stages")
  `ACRM_ASSERT(a_drain, (res_vld_q && !out_stall_i && !in_vld_q) |=> !res_vld_q, "item repeated on output")

endmodule
